### rtl/mhcc_pkg.sv
// ----------------------------------------------------------------------------
// mhcc_pkg
// shared constants for the magic hash collision counter
// ----------------------------------------------------------------------------
`default_nettype none

package mhcc_pkg;

    localparam int MAX_INDEX_BITS_DEF = 12;
    localparam int MAX_KEYS           = 4096;
    localparam int PRODUCT_BITS       = 64;
    localparam int HALF_W             = 32;
    localparam int VALUE_W            = 64;
    localparam int COUNT_W            = 13;
    localparam int EPOCH_W            = 8;
    localparam int CFG_ADDR_W         = 4;
    localparam int CFG_DATA_W         = 64;
    localparam int IDX_FIELD_W        = 4;
    localparam int SHIFT_W            = 7;

    localparam logic [IDX_FIELD_W-1:0] INDEX_BITS_RESET = 4'd12;

    // register index, taken from paddr bit 3
    localparam logic REG_MAGIC      = 1'b0;
    localparam logic REG_INDEX_BITS = 1'b1;

endpackage

`default_nettype wire

### rtl/mhcc_cfg.sv
// ----------------------------------------------------------------------------
// mhcc_cfg
// apb register file holding the magic multiplier and the index width
// ----------------------------------------------------------------------------
`default_nettype none

module mhcc_cfg
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mhcc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [mhcc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [mhcc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic      [mhcc_pkg::VALUE_W-1:0]         magic,
    output logic      [mhcc_pkg::IDX_FIELD_W-1:0]     index_bits
);

    logic [mhcc_pkg::VALUE_W-1:0]     magic_reg;
    logic [mhcc_pkg::IDX_FIELD_W-1:0] index_bits_reg;
    logic                             wr_en;
    logic                             reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg      <= '0;
            index_bits_reg <= mhcc_pkg::INDEX_BITS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mhcc_pkg::REG_MAGIC:      magic_reg      <= pwdata;
                mhcc_pkg::REG_INDEX_BITS: index_bits_reg <= pwdata[mhcc_pkg::IDX_FIELD_W-1:0];
                default:                  magic_reg      <= magic_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mhcc_pkg::REG_MAGIC:      prdata = magic_reg;
            mhcc_pkg::REG_INDEX_BITS: prdata = mhcc_pkg::CFG_DATA_W'(index_bits_reg);
            default:                  prdata = '0;
        endcase
    end

    assign magic      = magic_reg;
    assign index_bits = index_bits_reg;

endmodule

`default_nettype wire

### rtl/mhcc_mul.sv
// ----------------------------------------------------------------------------
// mhcc_mul
// low 64 bits of a 64x64 product on one shared 32x32 multiplier, four steps
// ----------------------------------------------------------------------------
`default_nettype none

module mhcc_mul
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [mhcc_pkg::PRODUCT_BITS-1:0]  op_a,
    input  wire logic [mhcc_pkg::PRODUCT_BITS-1:0]  op_b,
    output logic                                    done,
    output logic      [mhcc_pkg::PRODUCT_BITS-1:0]  product
);

    localparam int H = mhcc_pkg::HALF_W;

    logic                                busy_reg;
    logic [1:0]                          step_reg;
    logic [H-1:0]                        mul_a;
    logic [H-1:0]                        mul_b;
    logic [mhcc_pkg::PRODUCT_BITS-1:0]   mul_full;
    logic [mhcc_pkg::PRODUCT_BITS-1:0]   mul_reg;
    logic [mhcc_pkg::PRODUCT_BITS-1:0]   prod_reg;

    // lo*lo, then the two cross terms (only their low halves matter)
    always_comb
    begin
        unique case (step_reg)
            2'd0:    begin mul_a = op_a[H-1:0];   mul_b = op_b[H-1:0];   end
            2'd1:    begin mul_a = op_a[2*H-1:H]; mul_b = op_b[H-1:0];   end
            2'd2:    begin mul_a = op_a[H-1:0];   mul_b = op_b[2*H-1:H]; end
            default: begin mul_a = op_a[H-1:0];   mul_b = op_b[H-1:0];   end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mul_reg <= mul_full;
            unique case (step_reg)
                2'd0:    prod_reg <= prod_reg;
                2'd1:    prod_reg <= mul_reg;
                default: prod_reg[2*H-1:H] <= prod_reg[2*H-1:H] + mul_reg[H-1:0];
            endcase
        end
    end

    assign done    = busy_reg && (step_reg == 2'd3);
    assign product = prod_reg;

endmodule

`default_nettype wire

### rtl/mhcc_table.sv
// ----------------------------------------------------------------------------
// mhcc_table
// single-port slot memory with a registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mhcc_table
#(
    parameter int ADDR_W = mhcc_pkg::MAX_INDEX_BITS_DEF,
    parameter int DATA_W = mhcc_pkg::EPOCH_W + mhcc_pkg::VALUE_W
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/magic_hash_collision_counter.sv
// ----------------------------------------------------------------------------
// magic_hash_collision_counter
// checks a candidate magic multiplier against a stream of key/value pairs
//
//   channel  signals                                   direction
//   req      req_valid req_stall key value last        in
//   rsp      rsp_valid rsp_stall conflict              out
//            conflict_count set_done fits
//   cfg      psel penable pwrite paddr pwdata          in
//            prdata pready                             out
//
// a pair goes through accept, 4 steps of the shared 32x32 multiplier,
// index/read of the slot memory, check/write-back
// after reset, and after every 255th set, a clearing pass over all 2^MAX_INDEX_BITS
// slots rewrites the slot epochs; req_stall is high during it
// sets in between are cleared by advancing the epoch, at no cost
// a finished result waits in the output register; the next pair is accepted
// and only its check step waits while rsp_stall holds the previous result
// ----------------------------------------------------------------------------
`default_nettype none

module magic_hash_collision_counter
#(
    parameter int MAX_INDEX_BITS = mhcc_pkg::MAX_INDEX_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic [mhcc_pkg::VALUE_W-1:0]        key,
    input  wire logic [mhcc_pkg::VALUE_W-1:0]        value,
    input  wire logic                                last,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic                                     conflict,
    output logic      [mhcc_pkg::COUNT_W-1:0]        conflict_count,
    output logic                                     set_done,
    output logic                                     fits,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mhcc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mhcc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mhcc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int IDXW    = MAX_INDEX_BITS;
    localparam int VW      = mhcc_pkg::VALUE_W;
    localparam int EW      = mhcc_pkg::EPOCH_W;
    localparam int ENTRY_W = EW + VW;
    localparam int SW      = mhcc_pkg::SHIFT_W;
    localparam int CW      = mhcc_pkg::COUNT_W;
    localparam int COUNT_LIMIT_I = (mhcc_pkg::MAX_KEYS < 8191) ? mhcc_pkg::MAX_KEYS : 8191;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(COUNT_LIMIT_I);
    localparam logic [EW-1:0] EPOCH_FIRST = EW'(1);

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_INDEX,
        S_CHECK
    } state_t;

    state_t             state_reg;
    logic [IDXW-1:0]    clr_addr_reg;
    logic [EW-1:0]      epoch_reg;
    logic [CW-1:0]      count_reg;
    logic [IDXW-1:0]    idx_reg;
    logic [VW-1:0]      key_reg;
    logic [VW-1:0]      value_reg;
    logic               last_reg;
    logic               rsp_valid_reg;
    logic               conflict_reg;
    logic [CW-1:0]      count_out_reg;
    logic               set_done_reg;
    logic               fits_reg;

    logic [VW-1:0]                  magic;
    logic [mhcc_pkg::IDX_FIELD_W-1:0] index_bits;
    logic                           req_xfer;
    logic                           mul_done;
    logic [VW-1:0]                  product;
    logic [SW-1:0]                  bits_raw;
    logic [SW-1:0]                  bits_eff;
    logic [SW-1:0]                  shift_amt;
    logic [VW-1:0]                  shifted;
    logic [IDXW-1:0]                idx;
    logic                           tbl_we;
    logic [IDXW-1:0]                tbl_addr;
    logic [ENTRY_W-1:0]             tbl_wdata;
    logic [ENTRY_W-1:0]             tbl_rdata;
    logic [EW-1:0]                  rd_epoch;
    logic [VW-1:0]                  rd_value;
    logic                           occupied;
    logic                           hit_diff;
    logic                           proceed;
    logic [CW-1:0]                  count_new;

    mhcc_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .magic      (magic),
        .index_bits (index_bits)
    );

    mhcc_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req_xfer),
        .op_a    (key_reg),
        .op_b    (magic),
        .done    (mul_done),
        .product (product)
    );

    mhcc_table
    #(
        .ADDR_W (IDXW),
        .DATA_W (ENTRY_W)
    )
    u_table
    (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign pready    = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;

    // index width clamped to 1..MAX_INDEX_BITS
    assign bits_raw = SW'(index_bits);
    always_comb
    begin
        priority if (bits_raw == '0)
        begin
            bits_eff = SW'(1);
        end
        else if (bits_raw > SW'(MAX_INDEX_BITS))
        begin
            bits_eff = SW'(MAX_INDEX_BITS);
        end
        else
        begin
            bits_eff = bits_raw;
        end
    end

    assign shift_amt = SW'(mhcc_pkg::PRODUCT_BITS) - bits_eff;
    assign shifted   = product >> shift_amt;
    assign idx       = shifted[IDXW-1:0];

    assign rd_epoch  = tbl_rdata[ENTRY_W-1:VW];
    assign rd_value  = tbl_rdata[VW-1:0];
    assign occupied  = (rd_epoch == epoch_reg);
    assign hit_diff  = occupied && (rd_value != value_reg);
    assign proceed   = !rsp_valid_reg || !rsp_stall;
    assign count_new = (hit_diff && (count_reg < COUNT_LIMIT)) ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_addr  = idx_reg;
        tbl_wdata = {epoch_reg, value_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_addr  = clr_addr_reg;
                tbl_wdata = '0;
            end
            S_INDEX:
            begin
                tbl_addr = idx;
            end
            S_CHECK:
            begin
                tbl_we = proceed && !occupied && (value_reg != '0);
            end
            default:
            begin
                tbl_addr = idx_reg;
            end
        endcase
    end

    // pair payload
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            key_reg   <= key;
            value_reg <= value;
            last_reg  <= last;
        end
        if (state_reg == S_INDEX)
        begin
            idx_reg <= idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_FIRST;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            conflict_reg  <= 1'b0;
            count_out_reg <= '0;
            set_done_reg  <= 1'b0;
            fits_reg      <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CHECK && proceed)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + IDXW'(1);
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_INDEX;
                    end
                end
                S_INDEX:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (proceed)
                    begin
                        conflict_reg  <= hit_diff;
                        count_out_reg <= count_new;
                        set_done_reg  <= last_reg;
                        fits_reg      <= last_reg && (count_new == '0);
                        if (last_reg)
                        begin
                            count_reg <= '0;
                            if (epoch_reg == '1)
                            begin
                                epoch_reg    <= EPOCH_FIRST;
                                clr_addr_reg <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + EW'(1);
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            count_reg <= count_new;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign conflict       = conflict_reg;
    assign conflict_count = count_out_reg;
    assign set_done       = set_done_reg;
    assign fits           = fits_reg;

`ifndef SYNTHESIS
    // epoch zero marks a cleared slot and must never be live
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("live epoch is zero");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("conflict count above limit");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MUL)
        else $error("multiplier done outside multiply state");

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_we && state_reg == S_CHECK) |-> (value_reg != '0 && !occupied))
        else $error("slot written with zero or over an occupied slot");

    a_fits_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && fits_reg) |-> (set_done_reg && count_out_reg == '0))
        else $error("fits flagged on a result that is not a clean set end");
`endif

endmodule

`default_nettype wire
